// File: rtl/cidt_pkg.sv
// cidt_pkg: shared types and constants for the can identifier dispatch table
// holds the classified item struct passed from the front stage to the table stage
// no dependencies
package cidt_pkg;

   localparam int unsigned ID_W      = 11;
   localparam int unsigned TAG_W     = 8;
   localparam int unsigned LEN_W     = 4;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned SLOT_OUT_W = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;
   localparam int unsigned EXT_BIT_POS = 2;
   localparam int unsigned RTR_BIT_POS = 1;
   localparam int unsigned ID_LSB      = 21;

   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_FRAME    = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DISCARD  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DISPATCH = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;

   // one classified item on its way to the table
   typedef struct packed {
      logic              kind;
      logic              null_tag;
      logic              discard;
      logic [ID_W-1:0]   ident;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data_low;
      logic [DATA_W-1:0] data_high;
   } item_type;

endpackage

// File: rtl/can_id_dispatch_table.sv
// can_id_dispatch_table: top level of the standard can identifier dispatch table
// instantiates cidt_front, cidt_queue and cidt_back; depends on cidt_pkg
//
//   channel   | ports                        | handshake
//   ----------+------------------------------+------------------------------------
//   request   | start, busy, req_*           | transfer when start high, busy low
//   response  | rsp_valid, rsp_*             | one-cycle strobe, cannot be held off
//
// the response is registered in turn in the front register, the queue entry and then,
// through the table compare at the queue head, the result register, from which it
// sits on the rsp_ ports; a new item can be taken every cycle while busy is low
// the table compare and update are done as the item leaves the queue head, so items
// never wait on the table; busy only rises if the queue is full with the front
// register loaded
// reset is synchronous and clears slot valid marks, queue and strobes
module can_id_dispatch_table import cidt_pkg::*; #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [ID_W-1:0]       req_reg_id,
   input  logic [TAG_W-1:0]      req_handler_tag,
   input  logic [31:0]           req_id_word,
   input  logic [LEN_W-1:0]      req_len_word,
   input  logic [DATA_W-1:0]     req_data_low,
   input  logic [DATA_W-1:0]     req_data_high,
   // response channel
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [TAG_W-1:0]      rsp_handler_out,
   output logic [ID_W-1:0]       rsp_frame_id,
   output logic [LEN_W-1:0]      rsp_frame_len,
   output logic [DATA_W-1:0]     rsp_data_out_low,
   output logic [DATA_W-1:0]     rsp_data_out_high
);

   // front to queue
   logic     push;
   item_type push_item;
   logic     queue_full;

   // queue to table stage
   logic     pop;
   logic     queue_empty;
   item_type head;

   // front: classify kind, null tag, extended/remote discard, extract id, clamp length
   cidt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_reg_id      (req_reg_id),
      .req_handler_tag (req_handler_tag),
      .req_id_word     (req_id_word),
      .req_len_word    (req_len_word),
      .req_data_low    (req_data_low),
      .req_data_high   (req_data_high),
      .push            (push),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   // short fifo decoupling the front from the table stage
   cidt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   // table stage: parallel compare, first-match pick, update and response register
   cidt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (queue_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_handler_out   (rsp_handler_out),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_data_out_low  (rsp_data_out_low),
      .rsp_data_out_high (rsp_data_out_high)
   );

endmodule

// File: rtl/cidt_front.sv
// cidt_front: accepts request transfers, classifies them and holds one item
// depends on cidt_pkg
module cidt_front import cidt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic [ID_W-1:0]   req_reg_id,
   input  logic [TAG_W-1:0]  req_handler_tag,
   input  logic [31:0]       req_id_word,
   input  logic [LEN_W-1:0]  req_len_word,
   input  logic [DATA_W-1:0] req_data_low,
   input  logic [DATA_W-1:0] req_data_high,
   output logic              push,
   output item_type          push_item,
   input  logic              queue_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign push   = valid_ff && !queue_full;
   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;

   always_comb begin
      item_in.kind      = req_kind;
      item_in.null_tag  = (req_handler_tag == '0);
      item_in.discard   = req_id_word[EXT_BIT_POS] || req_id_word[RTR_BIT_POS];
      item_in.tag       = req_handler_tag;
      item_in.data_low  = req_data_low;
      item_in.data_high = req_data_high;
      item_in.len       = (req_len_word > LEN_MAX) ? LEN_MAX : req_len_word;
      if (req_kind == KIND_FRAME) begin
         item_in.ident = req_id_word[ID_LSB +: ID_W];
      end else begin
         item_in.ident = req_reg_id;
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_item = item_ff;

endmodule

// File: rtl/cidt_queue.sv
// cidt_queue: two-entry fifo of classified items between front and table stage
// depends on cidt_pkg
module cidt_queue import cidt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/cidt_back.sv
// cidt_back: slot table, identifier match, registration update and result register
// depends on cidt_pkg
module cidt_back import cidt_pkg::*; #(
   parameter int unsigned SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  item_type              head,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [TAG_W-1:0]      rsp_handler_out,
   output logic [ID_W-1:0]       rsp_frame_id,
   output logic [LEN_W-1:0]      rsp_frame_len,
   output logic [DATA_W-1:0]     rsp_data_out_low,
   output logic [DATA_W-1:0]     rsp_data_out_high
);

   localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]  ident_ff   [SLOTS];
   logic [TAG_W-1:0] handler_ff [SLOTS];

   logic              match_any, free_any;
   logic [SLOT_W-1:0] match_idx, free_idx;
   logic              wr_replace, wr_add;

   logic                  out_valid_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic [TAG_W-1:0]      handler_out_ff, handler_out_in;
   logic [ID_W-1:0]       frame_id_ff, frame_id_in;
   logic [LEN_W-1:0]      frame_len_ff, frame_len_in;
   logic [DATA_W-1:0]     dlo_ff, dlo_in, dhi_ff, dhi_in;

   assign pop = !empty;

   // lowest valid slot with the same identifier, lowest empty slot
   always_comb begin
      match_any = 1'b0;
      free_any  = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (ident_ff[i] == head.ident)) begin
            match_any = 1'b1;
            match_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      wr_replace     = 1'b0;
      wr_add         = 1'b0;
      status_in      = ST_NULL;
      slot_in        = '0;
      handler_out_in = '0;
      frame_id_in    = '0;
      frame_len_in   = '0;
      dlo_in         = '0;
      dhi_in         = '0;
      if (head.kind == KIND_REGISTER) begin
         if (head.null_tag) begin
            status_in = ST_NULL;
         end else if (match_any) begin
            wr_replace = pop;
            status_in  = ST_REPLACED;
            slot_in    = SLOT_OUT_W'(match_idx);
         end else if (free_any) begin
            wr_add    = pop;
            status_in = ST_ADDED;
            slot_in   = SLOT_OUT_W'(free_idx);
         end else begin
            status_in = ST_FULL;
         end
      end else if (head.discard) begin
         status_in = ST_DISCARD;
      end else begin
         frame_id_in  = head.ident;
         frame_len_in = head.len;
         dlo_in       = head.data_low;
         dhi_in       = head.data_high;
         if (match_any) begin
            status_in      = ST_DISPATCH;
            slot_in        = SLOT_OUT_W'(match_idx);
            handler_out_in = handler_ff[match_idx];
         end else begin
            status_in = ST_NONE;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_add) begin
         valid_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_add) begin
         ident_ff[free_idx]   <= head.ident;
         handler_ff[free_idx] <= head.tag;
      end else if (wr_replace) begin
         handler_ff[match_idx] <= head.tag;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      slot_ff        <= slot_in;
      handler_out_ff <= handler_out_in;
      frame_id_ff    <= frame_id_in;
      frame_len_ff   <= frame_len_in;
      dlo_ff         <= dlo_in;
      dhi_ff         <= dhi_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_handler_out   = handler_out_ff;
   assign rsp_frame_id      = frame_id_ff;
   assign rsp_frame_len     = frame_len_ff;
   assign rsp_data_out_low  = dlo_ff;
   assign rsp_data_out_high = dhi_ff;

endmodule

// File: tb/sv/tb_can_id_dispatch_table.sv
`timescale 1ns / 1ps
// tb_can_id_dispatch_table: self-checking testbench for the can identifier dispatch table
// runs a directed stimulus table and then random register and frame requests against a predictor
// depends on cidt_pkg and can_id_dispatch_table

module tb_can_id_dispatch_table;
   import cidt_pkg::*;

   localparam int TABLE_SLOTS   = 8;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int IDLE_LIMIT    = 1000;  // well above the longest sender gap
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_LIMIT  = 10;

   // one request as seen on the req_ ports
   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   reg_id;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       id_word;
      logic [LEN_W-1:0]  len_word;
      logic [DATA_W-1:0] data_low;
      logic [DATA_W-1:0] data_high;
   } table_req_type;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [TAG_W-1:0]      handler;
      logic [ID_W-1:0]       frame_id;
      logic [LEN_W-1:0]      frame_len;
      logic [DATA_W-1:0]     data_low;
      logic [DATA_W-1:0]     data_high;
   } dispatch_result_type;

   // directed row: typed marks a response written in by hand
   typedef struct packed {
      table_req_type       req;
      logic                typed;
      dispatch_result_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = 1'b0;
   logic [ID_W-1:0]       req_reg_id = '0;
   logic [TAG_W-1:0]      req_handler_tag = '0;
   logic [31:0]           req_id_word = '0;
   logic [LEN_W-1:0]      req_len_word = '0;
   logic [DATA_W-1:0]     req_data_low = '0;
   logic [DATA_W-1:0]     req_data_high = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [TAG_W-1:0]      rsp_handler_out;
   logic [ID_W-1:0]       rsp_frame_id;
   logic [LEN_W-1:0]      rsp_frame_len;
   logic [DATA_W-1:0]     rsp_data_out_low;
   logic [DATA_W-1:0]     rsp_data_out_high;

   // predictor copy of the handler table
   logic                  tbl_valid   [TABLE_SLOTS];
   logic [ID_W-1:0]       tbl_ident   [TABLE_SLOTS];
   logic [TAG_W-1:0]      tbl_handler [TABLE_SLOTS];

   dispatch_result_type   pending_rsp_q [$];
   stim_row_type          directed_rows [$];
   int                    mismatch_count = 0;
   int                    register_count = 0;
   int                    frame_count = 0;
   int                    status_seen [8];
   logic                  no_idle = 1'b0;

   can_id_dispatch_table #(.SLOTS(TABLE_SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_reg_id        (req_reg_id),
      .req_handler_tag   (req_handler_tag),
      .req_id_word       (req_id_word),
      .req_len_word      (req_len_word),
      .req_data_low      (req_data_low),
      .req_data_high     (req_data_high),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_handler_out   (rsp_handler_out),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_data_out_low  (rsp_data_out_low),
      .rsp_data_out_high (rsp_data_out_high)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // first valid slot holding ident, -1 if none
   function automatic int find_slot(input logic [ID_W-1:0] ident);
      int hit;
      hit = -1;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_ident[i] == ident) hit = i;
      end
      return hit;
   endfunction

   // computes the response of one request and updates the table copy
   function automatic dispatch_result_type predict_dispatch(input table_req_type r);
      dispatch_result_type res;
      int                  hit;
      logic [ID_W-1:0]     ident;
      res = '0;
      if (r.kind == KIND_REGISTER) begin
         if (r.tag == '0) begin
            res.status = ST_NULL;
         end else begin
            hit = find_slot(r.reg_id);
            if (hit >= 0) begin
               // same identifier already present: only the tag changes
               tbl_handler[hit] = r.tag;
               res.status = ST_REPLACED;
               res.slot = SLOT_OUT_W'(hit);
            end else begin
               // lowest empty slot, or full when there is none
               for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                  if (!tbl_valid[i]) hit = i;
               end
               if (hit >= 0) begin
                  tbl_valid[hit] = 1'b1;
                  tbl_ident[hit] = r.reg_id;
                  tbl_handler[hit] = r.tag;
                  res.status = ST_ADDED;
                  res.slot = SLOT_OUT_W'(hit);
               end else begin
                  res.status = ST_FULL;
               end
            end
         end
      end else if (r.id_word[EXT_BIT_POS] || r.id_word[RTR_BIT_POS]) begin
         // extended or remote frames leave every other field zero
         res.status = ST_DISCARD;
      end else begin
         ident = r.id_word[ID_LSB +: ID_W];
         res.frame_id = ident;
         res.frame_len = (r.len_word > LEN_MAX) ? LEN_MAX : r.len_word;
         res.data_low = r.data_low;
         res.data_high = r.data_high;
         hit = find_slot(ident);
         if (hit >= 0) begin
            res.status = ST_DISPATCH;
            res.slot = SLOT_OUT_W'(hit);
            res.handler = tbl_handler[hit];
         end else begin
            res.status = ST_NONE;
         end
      end
      return res;
   endfunction

   function automatic table_req_type reg_req(input logic [ID_W-1:0] id,
                                             input logic [TAG_W-1:0] tag);
      table_req_type r;
      r = '0;
      r.kind = KIND_REGISTER;
      r.reg_id = id;
      r.tag = tag;
      return r;
   endfunction

   function automatic table_req_type frame_req(input logic [31:0] idw,
                                               input logic [LEN_W-1:0] len,
                                               input logic [DATA_W-1:0] lo,
                                               input logic [DATA_W-1:0] hi);
      table_req_type r;
      r = '0;
      r.kind = KIND_FRAME;
      r.id_word = idw;
      r.len_word = len;
      r.data_low = lo;
      r.data_high = hi;
      return r;
   endfunction

   function automatic dispatch_result_type rsp_of(input logic [STATUS_W-1:0] st,
                                                  input logic [SLOT_OUT_W-1:0] sl,
                                                  input logic [TAG_W-1:0] hd,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [DATA_W-1:0] lo,
                                                  input logic [DATA_W-1:0] hi);
      return '{st, sl, hd, id, len, lo, hi};
   endfunction

   // random gap: mostly none, sometimes short, rarely long
   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // random request: mostly identifiers already in the table, some noise
   function automatic table_req_type random_req();
      table_req_type r;
      logic [ID_W-1:0] id;
      r.kind = ($urandom_range(0, 99) < 35) ? KIND_REGISTER : KIND_FRAME;
      id = ($urandom_range(0, 99) < 60) ? tbl_ident[$urandom_range(0, TABLE_SLOTS - 1)]
                                        : ID_W'($urandom);
      r.reg_id = (r.kind == KIND_REGISTER) ? id : ID_W'($urandom);
      r.tag = ($urandom_range(0, 9) == 0) ? TAG_W'(0) : TAG_W'($urandom_range(1, 255));
      r.id_word = {id, 21'($urandom)};
      if ($urandom_range(0, 99) < 80) begin
         // well-formed standard data frame
         r.id_word[EXT_BIT_POS] = 1'b0;
         r.id_word[RTR_BIT_POS] = 1'b0;
      end else begin
         r.id_word[EXT_BIT_POS:RTR_BIT_POS] = 2'($urandom_range(1, 3));
      end
      r.len_word = LEN_W'($urandom);
      r.data_low = $urandom;
      r.data_high = $urandom;
      return r;
   endfunction

   // drives one request until its transfer and queues the response it causes
   task automatic push_item(input table_req_type r, input logic typed,
                            input dispatch_result_type want);
      dispatch_result_type predicted;
      int                  gap;
      start <= 1'b1;
      req_kind <= r.kind;
      req_reg_id <= r.reg_id;
      req_handler_tag <= r.tag;
      req_id_word <= r.id_word;
      req_len_word <= r.len_word;
      req_data_low <= r.data_low;
      req_data_high <= r.data_high;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer taken at this edge
      predicted = predict_dispatch(r);
      pending_rsp_q.push_back(typed ? want : predicted);
      if (r.kind == KIND_REGISTER) register_count++;
      else frame_count++;
      gap = sender_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what, input dispatch_result_type got,
                                  input dispatch_result_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s at %0t: got st %0d slot %0d hd %h id %h len %0d data %h %h",
                  what, $realtime, got.status, got.slot, got.handler, got.frame_id,
                  got.frame_len, got.data_low, got.data_high);
         $display("   expected st %0d slot %0d hd %h id %h len %0d data %h %h",
                  want.status, want.slot, want.handler, want.frame_id, want.frame_len,
                  want.data_low, want.data_high);
      end
   endtask

   // response checker: every strobe is matched against the oldest prediction
   always @(posedge clock) begin : check_rsp
      dispatch_result_type got;
      dispatch_result_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_slot, rsp_handler_out, rsp_frame_id, rsp_frame_len,
                 rsp_data_out_low, rsp_data_out_high};
         if (rsp_status < 3'd7) status_seen[rsp_status]++;
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response with nothing pending", got, '0);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.status !== want.status || got.slot !== want.slot
                || got.handler !== want.handler || got.frame_id !== want.frame_id
                || got.frame_len !== want.frame_len || got.data_low !== want.data_low
                || got.data_high !== want.data_high) begin
               report_mismatch("response mismatch", got, want);
            end
         end
      end
   end

   // watchdog: ends the run after too many cycles without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("can_id_dispatch_table: mismatch");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_ident[i] = '0;
         tbl_handler[i] = '0;
      end
      for (int i = 0; i < 8; i++) status_seen[i] = 0;

      // directed table: empty table, extremes, discards, fill, full, null tag
      directed_rows.push_back('{frame_req(32'h0, 4'd0, 32'h0, 32'h0), 1'b1,
                                rsp_of(ST_NONE, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{reg_req(11'h000, 8'h00), 1'b1,
                                rsp_of(ST_NULL, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{reg_req(11'h7FF, 8'hFF), 1'b1,
                                rsp_of(ST_ADDED, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{frame_req(32'hFFE0_0000, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                1'b1, rsp_of(ST_DISPATCH, 3'd0, 8'hFF, 11'h7FF, LEN_MAX,
                                             32'hFFFF_FFFF, 32'hFFFF_FFFF)});
      // extended, remote, and both: all discarded
      directed_rows.push_back('{frame_req(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                1'b1, rsp_of(ST_DISCARD, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{frame_req(32'h0000_0004, 4'd8, 32'h1234_5678, 32'h9ABC_DEF0),
                                1'b1, rsp_of(ST_DISCARD, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{frame_req(32'h0000_0002, 4'd8, 32'h1234_5678, 32'h9ABC_DEF0),
                                1'b1, rsp_of(ST_DISCARD, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{frame_req(32'hFFE0_0006, 4'd3, 32'h0, 32'h0),
                                1'b1, rsp_of(ST_DISCARD, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{reg_req(11'h7FF, 8'h01), 1'b1,
                                rsp_of(ST_REPLACED, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      // fill the remaining seven slots
      directed_rows.push_back('{reg_req(11'h000, 8'h80), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h555, 8'h5A), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h2AA, 8'hA5), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h100, 8'h10), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h101, 8'h11), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h102, 8'h12), 1'b0, '0});
      directed_rows.push_back('{reg_req(11'h103, 8'h13), 1'b0, '0});
      // table full, then null tag on a known identifier
      directed_rows.push_back('{reg_req(11'h7FE, 8'h07), 1'b1,
                                rsp_of(ST_FULL, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{reg_req(11'h555, 8'h00), 1'b1,
                                rsp_of(ST_NULL, 3'd0, 8'h00, 11'h000, 4'd0, 32'h0, 32'h0)});
      directed_rows.push_back('{frame_req({11'h555, 21'h1F_FFF9}, 4'd9, 32'hA5A5_A5A5,
                                          32'h5A5A_5A5A), 1'b0, '0});
      directed_rows.push_back('{frame_req(32'h0000_0000, 4'd0, 32'h0, 32'h0), 1'b0, '0});
      directed_rows.push_back('{frame_req({11'h7FE, 21'h0}, 4'd8, 32'h0, 32'hFFFF_FFFF),
                                1'b0, '0});
      directed_rows.push_back('{reg_req(11'h103, 8'hFF), 1'b0, '0});
      directed_rows.push_back('{frame_req({11'h103, 21'h0}, 4'd7, 32'hDEAD_BEEF, 32'h0),
                                1'b0, '0});

      // synchronous reset first
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         push_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // stretches without any idling now and then
         if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         // sender waits for the table to drain at least once
         if (n == RANDOM_ITEMS / 2 && pending_rsp_q.size() != 0) begin
            start <= 1'b0;
            while (pending_rsp_q.size() != 0) @(posedge clock);
         end
         push_item(random_req(), 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d register and %0d frame requests, %0d mismatches",
               register_count, frame_count, mismatch_count);
      $display("responses: added %0d replaced %0d full %0d null %0d discard %0d hit %0d miss %0d",
               status_seen[ST_ADDED], status_seen[ST_REPLACED], status_seen[ST_FULL],
               status_seen[ST_NULL], status_seen[ST_DISCARD], status_seen[ST_DISPATCH],
               status_seen[ST_NONE]);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("can_id_dispatch_table: match");
      end else begin
         $display("can_id_dispatch_table: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/cidt_pkg.sv
rtl/cidt_front.sv
rtl/cidt_queue.sv
rtl/cidt_back.sv
rtl/can_id_dispatch_table.sv
tb/sv/tb_can_id_dispatch_table.sv
